### src/assert_macros.svh
// assertion helpers for the packet router, clocked on clk, disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every edge out of reset
`define SPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen out of reset
`define SPR_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SPR_ASSERT(lbl, prop, msg)
`define SPR_NEVER(lbl, cond, msg)
`endif
`endif

### src/spr_pkg.sv
`default_nettype none

package spr_pkg;

  localparam logic [7:0] MARKER        = 8'hAA;
  localparam logic [7:0] CRC_POLY      = 8'h8C;
  localparam int         CRC_BYTES     = 7;
  localparam logic [3:0] ADDR_BCAST    = 4'hF;
  localparam logic [7:0] NODE_ADDR_MIN = 8'd1;
  localparam logic [7:0] NODE_ADDR_MAX = 8'd14;
  localparam logic [7:0] REPLY_SRC_HI  = 8'hF0;

  localparam logic [1:0] KIND_TX = 2'd0;
  localparam logic [1:0] KIND_WR = 2'd1;
  localparam logic [1:0] KIND_RD = 2'd2;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // one classified packet handed from front to back
  typedef struct packed {
    logic [7:0][7:0] pkt;    // byte 0 oldest, data_0 already bumped for config
    logic            fwd;    // send the eight packet bytes
    logic            fresh;  // replace byte 7 with a recomputed crc
    logic            reply;  // follow with the identity reply packet
    logic            acc_en; // emit an access command after the bytes
    logic            acc_rd; // access command is a read request
    logic [3:0]      naddr;  // node address at classification time
  } spr_cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } spr_q_stat_t;

  function automatic logic [7:0] crc8_byte(logic [7:0] c, logic [7:0] d);
    logic [7:0] x;
    x = c ^ d;
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

`default_nettype wire

### src/spr_front.sv
`default_nettype none
`include "assert_macros.svh"

module spr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_rx_byte,
  output spr_pkg::spr_cmd_t    q_wdata,
  output logic                 q_push,
  input  spr_pkg::spr_q_stat_t q_stat
);
  import spr_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_CRC  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;
  localparam logic [2:0] CRC_LAST = 3'(CRC_BYTES - 1);

  logic [1:0]      state_r, state_nxt;
  logic [7:0][7:0] win_r, win_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic [7:0]      crc_r, crc_nxt;
  logic            crc_ok_r, crc_ok_nxt;
  logic [3:0]      node_r, node_nxt;
  logic [7:0]      crc_step;

  logic [3:0] rcp, snd;
  logic       dir, is_cfg, cfg_match, set_addr, has_result;
  logic [7:0] inc;
  spr_cmd_t   cmd;

  assign in_stall = (state_r != F_IDLE);
  assign crc_step = crc8_byte(crc_r, win_r[cnt_r]);

  // classification of the window once the crc is known good
  always_comb begin
    rcp       = win_r[1][3:0];
    snd       = win_r[1][7:4];
    dir       = win_r[2][7];
    is_cfg    = (win_r[1] == 8'd0);
    inc       = win_r[3] + 8'd1;
    cfg_match = (inc == win_r[5]);
    set_addr  = 1'b0;
    cmd       = '0;
    cmd.pkt   = win_r;
    cmd.naddr = node_r;
    if (is_cfg) begin
      cmd.pkt[3] = inc;
      cmd.fresh  = 1'b1;
      if (dir) begin
        cmd.fwd   = 1'b1;
        cmd.reply = 1'b1;
      end else if (cfg_match) begin
        set_addr = (win_r[6] inside {[NODE_ADDR_MIN:NODE_ADDR_MAX]});
      end else begin
        cmd.fwd = 1'b1;
      end
    end else begin
      cmd.fwd    = (rcp != node_r) && (snd != node_r);
      cmd.acc_en = (rcp == ADDR_BCAST) || (rcp == node_r);
      cmd.acc_rd = dir;
    end
    has_result = cmd.fwd | cmd.acc_en;
  end

  assign q_wdata = cmd;
  assign q_push  = (state_r == F_PUSH) && crc_ok_r && has_result && !q_stat.full;

  always_comb begin
    state_nxt  = state_r;
    win_nxt    = win_r;
    cnt_nxt    = cnt_r;
    crc_nxt    = crc_r;
    crc_ok_nxt = crc_ok_r;
    node_nxt   = node_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          win_nxt = {in_rx_byte, win_r[7:1]};
          cnt_nxt = 3'd0;
          crc_nxt = 8'd0;
          if (win_r[1] == MARKER) begin
            state_nxt = F_CRC;
          end
        end
      end
      F_CRC: begin
        crc_nxt = crc_step;
        if (cnt_r == CRC_LAST) begin
          crc_ok_nxt = (crc_step == win_r[7]);
          state_nxt  = F_PUSH;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      F_PUSH: begin
        if (!crc_ok_r) begin
          state_nxt = F_IDLE;
        end else if (!has_result) begin
          if (set_addr) begin
            node_nxt = win_r[6][3:0];
          end
          state_nxt = F_IDLE;
        end else if (!q_stat.full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      win_r    <= '0;
      node_r   <= 4'd0;
      crc_ok_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      win_r    <= win_nxt;
      node_r   <= node_nxt;
      crc_ok_r <= crc_ok_nxt;
    end
    cnt_r <= cnt_nxt;
    crc_r <= crc_nxt;
  end

  `SPR_ASSERT(a_push_hold, (state_r == F_PUSH && crc_ok_r && has_result && q_stat.full) |=> (state_r == F_PUSH), "front left push state while queue full")

endmodule

`default_nettype wire

### src/spr_queue.sv
`default_nettype none
`include "assert_macros.svh"

module spr_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  spr_pkg::spr_cmd_t    wdata,
  input  logic                 pop,
  output spr_pkg::spr_cmd_t    rdata,
  output spr_pkg::spr_q_stat_t stat
);
  import spr_pkg::*;

  spr_cmd_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r;

  function automatic logic [Q_PTR_W-1:0] ptr_inc(logic [Q_PTR_W-1:0] p);
    return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
  endfunction

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.valid = (cnt_r != '0);
  assign stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + Q_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - Q_CNT_W'(1);
      end
    end
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `SPR_NEVER(a_q_overflow, push && !pop && cnt_r == Q_CNT_W'(Q_DEPTH), "push into full queue")

endmodule

`default_nettype wire

### src/spr_back.sv
`default_nettype none
`include "assert_macros.svh"

module spr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [15:0]          cfg_device_id,
  input  spr_pkg::spr_cmd_t    q_rdata,
  input  spr_pkg::spr_q_stat_t q_stat,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_result_kind,
  output logic [7:0]           out_tx_byte,
  output logic [6:0]           out_point_num,
  output logic [31:0]          out_payload_word,
  output logic [3:0]           out_reply_to,
  output logic [7:0]           out_reply_tag,
  output logic                 out_last
);
  import spr_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_PKT  = 2'd1;
  localparam logic [1:0] B_RPL  = 2'd2;
  localparam logic [1:0] B_ACC  = 2'd3;
  localparam logic [2:0] IDX_CRC = 3'd7;

  logic [1:0]  state_r, state_nxt;
  spr_cmd_t    cmd_r, cmd_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] dev_id_r;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_result_kind_r, out_result_kind_nxt;
  logic [7:0]  out_tx_byte_r, out_tx_byte_nxt;
  logic [6:0]  out_point_num_r, out_point_num_nxt;
  logic [31:0] out_payload_word_r, out_payload_word_nxt;
  logic [3:0]  out_reply_to_r, out_reply_to_nxt;
  logic [7:0]  out_reply_tag_r, out_reply_tag_nxt;
  logic        out_last_r, out_last_nxt;

  logic       load;
  logic [7:0] pkt_byte, rpl_byte, cur_byte;

  assign load = !out_valid_r || !out_stall;

  assign pkt_byte = (idx_r == IDX_CRC && cmd_r.fresh) ? crc_r : cmd_r.pkt[idx_r];

  // identity reply, built on the fly from the bumped packet
  always_comb begin
    case (idx_r)
      3'd0:    rpl_byte = cmd_r.pkt[0];
      3'd1:    rpl_byte = REPLY_SRC_HI;
      3'd2:    rpl_byte = {1'b0, cmd_r.pkt[6][6:0]};
      3'd3:    rpl_byte = cmd_r.pkt[3];
      3'd4:    rpl_byte = dev_id_r[7:0];
      3'd5:    rpl_byte = dev_id_r[15:8];
      3'd6:    rpl_byte = {4'd0, cmd_r.naddr};
      default: rpl_byte = crc_r;
    endcase
  end

  assign cur_byte = (state_r == B_RPL) ? rpl_byte : pkt_byte;

  always_comb begin
    state_nxt            = state_r;
    cmd_nxt              = cmd_r;
    idx_nxt              = idx_r;
    crc_nxt              = crc_r;
    q_pop                = 1'b0;
    out_valid_nxt        = out_valid_r;
    out_result_kind_nxt  = out_result_kind_r;
    out_tx_byte_nxt      = out_tx_byte_r;
    out_point_num_nxt    = out_point_num_r;
    out_payload_word_nxt = out_payload_word_r;
    out_reply_to_nxt     = out_reply_to_r;
    out_reply_tag_nxt    = out_reply_tag_r;
    out_last_nxt         = out_last_r;
    if (load) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      B_IDLE: begin
        if (q_stat.valid) begin
          cmd_nxt   = q_rdata;
          q_pop     = 1'b1;
          idx_nxt   = 3'd0;
          crc_nxt   = 8'd0;
          state_nxt = q_rdata.fwd ? B_PKT : B_ACC;
        end
      end
      B_PKT, B_RPL: begin
        if (load) begin
          out_valid_nxt        = 1'b1;
          out_result_kind_nxt  = KIND_TX;
          out_tx_byte_nxt      = cur_byte;
          out_point_num_nxt    = 7'd0;
          out_payload_word_nxt = 32'd0;
          out_reply_to_nxt     = 4'd0;
          out_reply_tag_nxt    = 8'd0;
          out_last_nxt         = 1'b0;
          idx_nxt              = idx_r + 3'd1;
          if (idx_r == IDX_CRC) begin
            crc_nxt = 8'd0;
            if (state_r == B_PKT && cmd_r.reply) begin
              state_nxt = B_RPL;
            end else if (cmd_r.acc_en) begin
              state_nxt = B_ACC;
            end else begin
              out_last_nxt = 1'b1;
              state_nxt    = B_IDLE;
            end
          end else begin
            crc_nxt = crc8_byte(crc_r, cur_byte);
          end
        end
      end
      B_ACC: begin
        if (load) begin
          out_valid_nxt        = 1'b1;
          out_result_kind_nxt  = cmd_r.acc_rd ? KIND_RD : KIND_WR;
          out_tx_byte_nxt      = 8'd0;
          out_point_num_nxt    = cmd_r.pkt[2][6:0];
          out_payload_word_nxt = cmd_r.acc_rd ? 32'd0 :
                                 {cmd_r.pkt[6], cmd_r.pkt[5], cmd_r.pkt[4], cmd_r.pkt[3]};
          out_reply_to_nxt     = cmd_r.acc_rd ? cmd_r.pkt[1][7:4] : 4'd0;
          out_reply_tag_nxt    = cmd_r.acc_rd ? cmd_r.pkt[6] : 8'd0;
          out_last_nxt         = 1'b1;
          state_nxt            = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      dev_id_r    <= 16'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        dev_id_r <= cfg_device_id;
      end
    end
    cmd_r              <= cmd_nxt;
    idx_r              <= idx_nxt;
    crc_r              <= crc_nxt;
    out_result_kind_r  <= out_result_kind_nxt;
    out_tx_byte_r      <= out_tx_byte_nxt;
    out_point_num_r    <= out_point_num_nxt;
    out_payload_word_r <= out_payload_word_nxt;
    out_reply_to_r     <= out_reply_to_nxt;
    out_reply_tag_r    <= out_reply_tag_nxt;
    out_last_r         <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_result_kind_r;
  assign out_tx_byte      = out_tx_byte_r;
  assign out_point_num    = out_point_num_r;
  assign out_payload_word = out_payload_word_r;
  assign out_reply_to     = out_reply_to_r;
  assign out_reply_tag    = out_reply_tag_r;
  assign out_last         = out_last_r;

  `SPR_ASSERT(a_tx_clean,
              (out_valid_r && out_result_kind_r != KIND_TX) |-> (out_tx_byte_r == 8'd0),
              "access result carries a tx byte")
  `SPR_NEVER(a_kind_code,
             out_valid_r && out_result_kind_r != KIND_TX && out_result_kind_r != KIND_WR
             && out_result_kind_r != KIND_RD,
             "undefined result kind")
  `SPR_ASSERT(a_pop_start,
              q_pop |=> (state_r == B_PKT || state_r == B_ACC),
              "pop did not start a command")

endmodule

`default_nettype wire

### src/serial_packet_node_router_top.sv
// channel | direction | transfer when         | payload
// in      | input     | in_valid & !in_stall  | in_rx_byte
// out     | output    | out_valid & !out_stall| kind, tx byte, access fields, last
// cfg     | input     | cfg_wr_en             | cfg_device_id
//
// a byte whose window has no marker at its oldest slot is taken without raising in_stall
// a byte that exposes a marker goes through accept, 7 crc steps, classify
// the back end pops a command, then gives one result per cycle while out_stall is low (up to 16 per byte)
// so a config read with its reply gives 16 results: the 8 packet bytes and the 8 reply bytes
// reset is synchronous on rst_n low and clears window, node address, device id
// out stalls back up through a 2-entry command queue into in_stall
`default_nettype none

module serial_packet_node_router_top (
  input  logic        clk,
  input  logic        rst_n,
  // input byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_tx_byte,
  output logic [6:0]  out_point_num,
  output logic [31:0] out_payload_word,
  output logic [3:0]  out_reply_to,
  output logic [7:0]  out_reply_tag,
  output logic        out_last,
  // device identity register
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_device_id
);
  import spr_pkg::*;

  // classified packets between front and back
  spr_cmd_t    q_wdata;
  spr_cmd_t    q_rdata;
  spr_q_stat_t q_stat;
  logic        q_push;
  logic        q_pop;

  // front: sliding window, serial crc check, routing decision, node address
  spr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_wdata    (q_wdata),
    .q_push     (q_push),
    .q_stat     (q_stat)
  );

  // short command queue so each side stalls on its own
  spr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // back: byte sequencer with running crc for rewritten packets and replies
  spr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_device_id    (cfg_device_id),
    .q_rdata          (q_rdata),
    .q_stat           (q_stat),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_tx_byte      (out_tx_byte),
    .out_point_num    (out_point_num),
    .out_payload_word (out_payload_word),
    .out_reply_to     (out_reply_to),
    .out_reply_tag    (out_reply_tag),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

### sim/spr_route_checker.sv
`timescale 1ns / 1ps

module spr_route_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_result_kind,
  input  logic [7:0]  out_tx_byte,
  input  logic [6:0]  out_point_num,
  input  logic [31:0] out_payload_word,
  input  logic [3:0]  out_reply_to,
  input  logic [7:0]  out_reply_tag,
  input  logic        out_last,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_device_id,
  output int          fail_count,
  output int          pending
);
  import spr_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx;
    logic [6:0]  ap;
    logic [31:0] pay;
    logic [3:0]  rto;
    logic [7:0]  tag;
    logic        last;
  } route_result_t;

  route_result_t expected_routes[$];
  route_result_t batch[$];

  logic [7:0]  byte_window [8];
  logic [2:0]  slot;
  logic [3:0]  node_addr;
  logic [15:0] device_id_q;

  // reflected crc-8 over packet bytes 0..6
  function automatic logic [7:0] crc_head(input logic [7:0][7:0] pk);
    logic [7:0] c;
    c = 8'h00;
    for (int b = 0; b < 7; b++) begin
      c = c ^ pk[b];
      for (int i = 0; i < 8; i++) begin
        c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
      end
    end
    return c;
  endfunction

  task emit_packet(input logic [7:0][7:0] pk);
    route_result_t r;
    for (int k = 0; k < 8; k++) begin
      r = '0;
      r.kind = KIND_TX;
      r.tx = pk[k];
      batch.push_back(r);
    end
  endtask

  task predict_route(input logic [7:0] b);
    logic [7:0][7:0] pk;
    logic [3:0]      rcp;
    logic [3:0]      snd;
    logic            dir;
    logic [2:0]      idx;
    route_result_t   r;
    batch.delete();
    byte_window[slot] = b;
    slot = slot + 3'd1;
    if (byte_window[slot] == MARKER) begin
      for (int k = 0; k < 8; k++) begin
        idx = slot + k[2:0];
        pk[k] = byte_window[idx];
      end
      if (crc_head(pk) == pk[7]) begin
        rcp = pk[1][3:0];
        snd = pk[1][7:4];
        dir = pk[2][7];
        if (rcp == 4'd0 && snd == 4'd0) begin
          pk[3] = pk[3] + 8'd1;
          if (dir) begin
            pk[7] = crc_head(pk);
            emit_packet(pk);
            // identity reply built on the bumped packet
            pk[1] = REPLY_SRC_HI | {4'h0, rcp};
            pk[2] = {1'b0, pk[6][6:0]};
            pk[4] = device_id_q[7:0];
            pk[5] = device_id_q[15:8];
            pk[6] = {4'h0, node_addr};
            pk[7] = crc_head(pk);
            emit_packet(pk);
          end else if (pk[3] == pk[5]) begin
            if (pk[6] >= NODE_ADDR_MIN && pk[6] <= NODE_ADDR_MAX) node_addr = pk[6][3:0];
          end else begin
            pk[7] = crc_head(pk);
            emit_packet(pk);
          end
        end else begin
          if (rcp != node_addr && snd != node_addr) emit_packet(pk);
          if (rcp == ADDR_BCAST || rcp == node_addr) begin
            r = '0;
            r.ap = pk[2][6:0];
            if (dir) begin
              r.kind = KIND_RD;
              r.rto = snd;
              r.tag = pk[6];
            end else begin
              r.kind = KIND_WR;
              r.pay = pk[6:3];
            end
            batch.push_back(r);
          end
        end
      end
    end
    if (batch.size() > 0) begin
      r = batch.pop_back();
      r.last = 1'b1;
      batch.push_back(r);
    end
    foreach (batch[i]) expected_routes.push_back(batch[i]);
  endtask

  task check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    route_result_t want;
    if (!rst_n) begin
      foreach (byte_window[i]) byte_window[i] = 8'h00;
      slot = 3'd0;
      node_addr = 4'd0;
      device_id_q = 16'h0000;
      expected_routes.delete();
    end else begin
      if (cfg_wr_en) device_id_q = cfg_device_id;
      if (in_valid && !in_stall) predict_route(in_rx_byte);
      if (out_valid && !out_stall) begin
        if (expected_routes.size() == 0) begin
          fail_count++;
          $display("%0t unexpected result: expected none, actual kind %0h tx %0h last %0b",
                   $time, out_result_kind, out_tx_byte, out_last);
        end else begin
          want = expected_routes.pop_front();
          check_field("result_kind", 32'(want.kind), 32'(out_result_kind));
          check_field("tx_byte", 32'(want.tx), 32'(out_tx_byte));
          check_field("point_num", 32'(want.ap), 32'(out_point_num));
          check_field("payload_word", want.pay, out_payload_word);
          check_field("reply_to", 32'(want.rto), 32'(out_reply_to));
          check_field("reply_tag", 32'(want.tag), 32'(out_reply_tag));
          check_field("last", 32'(want.last), 32'(out_last));
        end
      end
    end
    pending = expected_routes.size();
  end

endmodule

### sim/serial_packet_node_router_top_tb.sv
`timescale 1ns / 1ps

module serial_packet_node_router_top_tb;
  import spr_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_result_kind;
  logic [7:0]  out_tx_byte;
  logic [6:0]  out_point_num;
  logic [31:0] out_payload_word;
  logic [3:0]  out_reply_to;
  logic [7:0]  out_reply_tag;
  logic        out_last;
  logic        cfg_wr_en;
  logic [15:0] cfg_device_id;

  int fail_count;
  int pending;

  // sender bookkeeping
  int         bytes_sent;
  int         burst_left;
  // best guess of the node address, only used to aim packets at this node
  logic [3:0] node_guess;

  serial_packet_node_router_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_tx_byte      (out_tx_byte),
    .out_point_num    (out_point_num),
    .out_payload_word (out_payload_word),
    .out_reply_to     (out_reply_to),
    .out_reply_tag    (out_reply_tag),
    .out_last         (out_last),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_device_id    (cfg_device_id)
  );

  // watches both channels and the config port, predicts and compares
  spr_route_checker route_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_tx_byte      (out_tx_byte),
    .out_point_num    (out_point_num),
    .out_payload_word (out_payload_word),
    .out_reply_to     (out_reply_to),
    .out_reply_tag    (out_reply_tag),
    .out_last         (out_last),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_device_id    (cfg_device_id),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // crc for building well-formed packets on the stimulus side
  function automatic logic [7:0] frame_crc(input logic [7:0][7:0] pk);
    logic [7:0] c;
    c = 8'h00;
    for (int b = 0; b < 7; b++) begin
      c = c ^ pk[b];
      for (int i = 0; i < 8; i++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
    end
    return c;
  endfunction

  // data is {data_3, data_2, data_1, data_0}
  function automatic logic [7:0][7:0] make_packet(input logic [3:0] rcp, input logic [3:0] snd,
                                                  input logic dir, input logic [6:0] ap,
                                                  input logic [31:0] data);
    logic [7:0][7:0] pk;
    pk[0] = MARKER;
    pk[1] = {snd, rcp};
    pk[2] = {dir, ap};
    pk[6:3] = data;
    pk[7] = frame_crc(pk);
    return pk;
  endfunction

  // this node or broadcast half the time, anyone otherwise
  function automatic logic [3:0] pick_addr();
    case ($urandom_range(0, 3))
      0: return node_guess;
      1: return ADDR_BCAST;
      default: return 4'($urandom_range(0, 15));
    endcase
  endfunction

  // one transfer on the input channel, with bursts and random gaps in between
  task send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_rx_byte <= b;
    // stall is read right at the edge, before the block updates
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task send_packet(input logic [7:0][7:0] pk, input bit corrupt);
    if (corrupt) pk[7] = pk[7] ^ 8'($urandom_range(1, 255));
    for (int k = 0; k < 8; k++) send_byte(pk[k]);
  endtask

  // device id only changes with the block drained and quiet
  task configure(input logic [15:0] id);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    // a marker byte with no result can still be in the crc steps
    repeat (30) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_device_id <= id;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    burst_left = 0;
  endtask

  // one random chunk of traffic: mostly good packets, some noise and broken ones
  task random_traffic();
    logic [7:0][7:0] pk;
    logic [31:0]     data;
    int              sel;
    int              n;
    sel = $urandom_range(0, 19);
    data = $urandom;
    if (sel < 14) begin
      case (sel)
        0, 1: pk = make_packet(4'd0, 4'd0, 1'b1, 7'($urandom), data);
        2, 3: begin
          // address set: data_2 is data_0 plus one
          data[23:16] = data[7:0] + 8'd1;
          data[31:24] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(15, 255))
                                                    : 8'($urandom_range(0, 15));
          if (data[31:24] >= NODE_ADDR_MIN && data[31:24] <= NODE_ADDR_MAX)
            node_guess = data[27:24];
          pk = make_packet(4'd0, 4'd0, 1'b0, 7'($urandom), data);
        end
        4: begin
          // config write that misses the address-set check, gets forwarded
          data[23:16] = data[7:0] + 8'd2 + 8'($urandom_range(0, 253));
          pk = make_packet(4'd0, 4'd0, 1'b0, 7'($urandom), data);
        end
        default: pk = make_packet(pick_addr(), pick_addr(), 1'($urandom), 7'($urandom), data);
      endcase
      send_packet(pk, $urandom_range(0, 9) == 0);
    end else if (sel < 17) begin
      // line noise, sometimes with stray markers
      n = $urandom_range(1, 7);
      repeat (n) send_byte(($urandom_range(0, 3) == 0) ? MARKER : 8'($urandom));
    end else begin
      // truncated packet
      n = $urandom_range(1, 6);
      send_byte(MARKER);
      repeat (n) send_byte(8'($urandom));
    end
  endtask

  // receiver stalls on its own pattern of segments, every fortieth a long hold-off
  initial begin
    int seg;
    int len;
    int mode;
    out_stall = 1'b0;
    seg = 0;
    wait (rst_n === 1'b1);
    forever begin
      seg++;
      if (seg % 40 == 8) begin
        // long hold so the queue fills and in_stall backs up
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (600) @(negedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        len = $urandom_range(10, 80);
        repeat (len) begin
          @(negedge clk);
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= 1'($urandom);
          endcase
        end
      end
    end
  end

  // hard stop for a hung run
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int start;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    cfg_wr_en = 1'b0;
    cfg_device_id = 16'h0000;
    rst_n = 1'b0;
    bytes_sent = 0;
    burst_left = 0;
    node_guess = 4'd0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    configure(16'hFFFF);

    // directed: byte extremes, each packet kind and every special case
    send_byte(8'h00);
    send_byte(8'hFF);
    // config read with data_0 wrapping and tag 0xff as reply access point
    send_packet(make_packet(4'd0, 4'd0, 1'b1, 7'h00, 32'hFF00_00FF), 1'b0);
    // config write forwarded: data_2 is not data_0 plus one
    send_packet(make_packet(4'd0, 4'd0, 1'b0, 7'h7F, 32'h0000_1234), 1'b0);
    // address set to the top value, data_0 wraps, marker value inside the data
    send_packet(make_packet(4'd0, 4'd0, 1'b0, 7'h00, 32'h0E00_AAFF), 1'b0);
    // address set with 15 and with 0: ignored, nothing sent
    send_packet(make_packet(4'd0, 4'd0, 1'b0, 7'h01, 32'h0F11_0010), 1'b0);
    send_packet(make_packet(4'd0, 4'd0, 1'b0, 7'h01, 32'h0011_0010), 1'b0);
    // config read now reports the address
    send_packet(make_packet(4'd0, 4'd0, 1'b1, 7'h55, 32'h8000_0000), 1'b0);
    // address set to the bottom value
    send_packet(make_packet(4'd0, 4'd0, 1'b0, 7'h02, 32'h0101_0000), 1'b0);
    node_guess = 4'd1;
    // foreign write, forwarded only
    send_packet(make_packet(4'd3, 4'd5, 1'b0, 7'h12, 32'hDEAD_BEEF), 1'b0);
    // own write and own read
    send_packet(make_packet(4'd1, 4'd9, 1'b0, 7'h7F, 32'hFFFF_FFFF), 1'b0);
    send_packet(make_packet(4'd1, 4'd15, 1'b1, 7'h00, 32'hA500_0000), 1'b0);
    // broadcast write from elsewhere: forwarded and then the access command
    send_packet(make_packet(4'd15, 4'd7, 1'b0, 7'h01, 32'h0000_0000), 1'b0);
    // broadcast read from this node: command only
    send_packet(make_packet(4'd15, 4'd1, 1'b1, 7'h40, 32'h1234_5678), 1'b0);
    // own sender, other recipient: dropped
    send_packet(make_packet(4'd4, 4'd1, 1'b0, 7'h02, 32'h0000_0000), 1'b0);
    // foreign read
    send_packet(make_packet(4'd6, 4'd2, 1'b1, 7'h33, 32'h0102_0304), 1'b0);
    // bad crc
    send_packet(make_packet(4'd1, 4'd2, 1'b0, 7'h11, 32'h5555_5555), 1'b1);

    // random phases, device id changed between them
    configure(16'($urandom_range(0, 65535)));
    start = bytes_sent;
    while (bytes_sent < start + 80) random_traffic();
    configure(16'h0000);
    start = bytes_sent;
    while (bytes_sent < start + 80) random_traffic();
    configure(16'($urandom_range(0, 65535)));
    start = bytes_sent;
    while (bytes_sent < start + 80) random_traffic();

    // drain, then give stray results time to show up
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
